// ----- sv/awvn_pkg.sv -----
`default_nettype none
package awvn_pkg;

    localparam int UNIQUE_VERTICES_DEF = 1024;

    localparam int CMD_W  = 2;
    localparam int ID_W   = 10;
    localparam int POS_W  = 16;
    localparam int NRM_W  = 16;
    localparam int OUT_W  = 16;
    localparam int CFG_W  = 32;
    localparam int ACC_W  = 64;
    localparam int RAD_W  = 72;
    localparam int ROOT_W = 36;

    localparam logic [CFG_W-1:0] MIN_AREA_RESET = 32'd1;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_ADD   = 2'd0;
    localparam t_cmd CMD_QUERY = 2'd1;
    localparam t_cmd CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
    } t_acc;

endpackage
`default_nettype wire

// ----- sv/awvn_ifs.sv -----
`default_nettype none
interface awvn_in_if import awvn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [ID_W-1:0]         vertex_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;

    modport source (
        output valid, command, vertex_id, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
        input  ready
    );
    modport sink (
        input  valid, command, vertex_id, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
        output ready
    );
endinterface

interface awvn_out_if import awvn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic                    sum_zero;

    modport source (output valid, out_x, out_y, out_z, sum_zero, input ready);
    modport sink   (input valid, out_x, out_y, out_z, sum_zero, output ready);
endinterface
`default_nettype wire

// ----- sv/awvn_store.sv -----
`default_nettype none
module awvn_store import awvn_pkg::*; #(
    parameter int DEPTH = UNIQUE_VERTICES_DEF,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_acc               o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  t_acc               i_wr_data
);

    t_acc r_mem [DEPTH];
    t_acc r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- sv/awvn_isqrt.sv -----
`default_nettype none
module awvn_isqrt import awvn_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+1:0] w_rem_sh;
    logic [ROOT_W+1:0] w_trial;
    logic              w_ge;

    assign w_rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 6'(ROOT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], w_ge};
                r_rad  <= r_rad << 2;
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ----- sv/area_weighted_vertex_normals_unit.sv -----
// Area-weighted vertex normal accumulator.
// Requests arrive on i_req (valid/ready); only a query produces a response on o_rsp.
// An add request holding the first or second corner of a triangle is only stored.
// The third corner starts the triangle: edges, cross product, sum of squares, a
// bit-serial square root of 36 steps and up to three read-modify-write passes
// through read, multiply and write states over the accumulator memory.
// A query reads the memory, scales the sum down one bit per cycle, squares, takes
// the root and divides each component in 15 steps, using the shared root unit.
// A clear request, and reset, run a clearing pass that zeroes the memory one entry
// per cycle; no request is taken meanwhile, though min_area writes on i_cfg_we are
// taken at any time. Reset sets min_area to one.
// The response is held in an output register until o_rsp.ready is high. While a
// stalled receiver holds it, new requests are still taken; a further query waits
// at its end until the output register is free, and no request is taken meanwhile.
`default_nettype none
module area_weighted_vertex_normals_unit import awvn_pkg::*; #(
    parameter int UNIQUE_VERTICES = UNIQUE_VERTICES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    awvn_in_if.sink               i_req,
    awvn_out_if.source            o_rsp
);

    localparam int AW = (UNIQUE_VERTICES > 1) ? $clog2(UNIQUE_VERTICES) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EDGE, S_CROSS, S_SQ, S_SQRT, S_CRD, S_CMUL, S_CWR,
        S_QDATA, S_QSHIFT, S_DIVLD, S_DIV, S_QOUT
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]  r_min_area;
    logic [1:0]        r_cnt;
    logic [1:0]        r_k;
    logic              r_qmode;
    logic [AW-1:0]     r_addr;
    logic [47:0]       r_cp [2];
    logic [47:0]       r_cn [2];
    logic [ID_W-1:0]   r_cid [2];
    logic [47:0]       r_p2;
    logic [47:0]       r_n2;
    logic [ID_W-1:0]   r_id2;
    logic signed [16:0] r_ea [3];
    logic signed [16:0] r_eb [3];
    logic [34:0]       r_c [3];
    logic [RAD_W-1:0]  r_sum;
    logic [ROOT_W-1:0] r_area;
    logic [31:0]       r_len;
    logic signed [52:0] r_pr [3];
    logic [ACC_W-1:0]  r_m [3];
    logic              r_neg [3];
    logic [46:0]       r_num;
    logic [46:0]       r_dsr;
    logic [14:0]       r_q;
    logic [3:0]        r_dcnt;
    logic signed [OUT_W-1:0] r_qo [3];
    logic              r_qz;
    logic              r_ov;
    logic signed [OUT_W-1:0] r_ox;
    logic signed [OUT_W-1:0] r_oy;
    logic signed [OUT_W-1:0] r_oz;
    logic              r_osz;

    logic              w_acc_req;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    t_acc              w_wr_data;
    t_acc              w_rd_data;
    logic [ID_W-1:0]   w_cid;
    logic [47:0]       w_cn;
    logic              w_cin;
    logic              w_qin;
    logic signed [16:0] w_m1a, w_m1b, w_m2a, w_m2b;
    logic signed [33:0] w_p1, w_p2;
    logic signed [34:0] w_cr;
    logic [34:0]       w_sq_in;
    logic [69:0]       w_sq;
    logic              w_sqrt_start;
    logic              w_sqrt_done;
    logic [ROOT_W-1:0] w_root;
    logic signed [36:0] w_area_s;
    logic              w_ge;
    logic [14:0]       w_qfin;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [52:0]      b
    );
        logic signed [ACC_W:0] s;
        s = 65'(a) + 65'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

    assign w_acc_req = i_req.valid && i_req.ready;
    assign w_qin     = (32'(i_req.vertex_id) < UNIQUE_VERTICES);

    always_comb begin
        unique case (r_k)
            2'd0: begin
                w_cid = r_cid[0];
                w_cn  = r_cn[0];
            end
            2'd1: begin
                w_cid = r_cid[1];
                w_cn  = r_cn[1];
            end
            default: begin
                w_cid = r_id2;
                w_cn  = r_n2;
            end
        endcase
    end
    assign w_cin = (32'(w_cid) < UNIQUE_VERTICES);

    always_comb begin
        unique case (r_k)
            2'd0: begin
                w_m1a = r_ea[1]; w_m1b = r_eb[2]; w_m2a = r_ea[2]; w_m2b = r_eb[1];
            end
            2'd1: begin
                w_m1a = r_ea[2]; w_m1b = r_eb[0]; w_m2a = r_ea[0]; w_m2b = r_eb[2];
            end
            default: begin
                w_m1a = r_ea[0]; w_m1b = r_eb[1]; w_m2a = r_ea[1]; w_m2b = r_eb[0];
            end
        endcase
    end
    assign w_p1 = w_m1a * w_m1b;
    assign w_p2 = w_m2a * w_m2b;
    assign w_cr = 35'(w_p1) - 35'(w_p2);

    assign w_sq_in  = r_qmode ? {4'b0, r_m[r_k][30:0]} : r_c[r_k];
    assign w_sq     = w_sq_in * w_sq_in;
    assign w_area_s = $signed({1'b0, r_area});

    assign w_ge   = (r_num >= r_dsr);
    assign w_qfin = {r_q[13:0], w_ge};

    assign w_sqrt_start = (r_state == S_SQ) && (r_k == 2'd2);

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = AW'(w_cid);
        w_wr_en   = 1'b0;
        w_wr_addr = AW'(w_cid);
        w_wr_data.x = sat_add(w_rd_data.x, r_pr[0]);
        w_wr_data.y = sat_add(w_rd_data.y, r_pr[1]);
        w_wr_data.z = sat_add(w_rd_data.z, r_pr[2]);
        unique case (r_state)
            S_IDLE: begin
                w_rd_addr = AW'(i_req.vertex_id);
                w_rd_en   = w_acc_req && (i_req.command == CMD_QUERY) && w_qin;
            end
            S_CRD: begin
                w_rd_en = w_cin;
            end
            S_CWR: begin
                w_wr_en = 1'b1;
            end
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_addr;
                w_wr_data = '0;
            end
            default: begin
            end
        endcase
    end

    awvn_store #(
        .DEPTH (UNIQUE_VERTICES),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    awvn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (r_sum + 72'(w_sq)),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_area <= MIN_AREA_RESET;
        end else if (i_cfg_we) begin
            r_min_area <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_ov    <= 1'b0;
            r_qmode <= 1'b0;
        end else begin
            if (r_ov && o_rsp.ready && (r_state != S_QOUT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == AW'(UNIQUE_VERTICES - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_acc_req) begin
                        if (i_req.command == CMD_ADD) begin
                            if (r_cnt == 2'd2) begin
                                r_p2    <= {i_req.pos_x, i_req.pos_y, i_req.pos_z};
                                r_n2    <= {i_req.norm_x, i_req.norm_y, i_req.norm_z};
                                r_id2   <= i_req.vertex_id;
                                r_cnt   <= '0;
                                r_state <= S_EDGE;
                            end else begin
                                r_cp[r_cnt[0]]  <= {i_req.pos_x, i_req.pos_y, i_req.pos_z};
                                r_cn[r_cnt[0]]  <= {i_req.norm_x, i_req.norm_y, i_req.norm_z};
                                r_cid[r_cnt[0]] <= i_req.vertex_id;
                                r_cnt           <= r_cnt + 2'd1;
                            end
                        end else if (i_req.command == CMD_QUERY) begin
                            if (w_qin) begin
                                r_state <= S_QDATA;
                            end else begin
                                r_qo[0] <= '0;
                                r_qo[1] <= '0;
                                r_qo[2] <= '0;
                                r_qz    <= 1'b1;
                                r_state <= S_QOUT;
                            end
                        end else if (i_req.command == CMD_CLEAR) begin
                            r_cnt   <= '0;
                            r_addr  <= '0;
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_ea[i] <= 17'($signed(r_cp[1][47-16*i -: 16]))
                                 - 17'($signed(r_cp[0][47-16*i -: 16]));
                        r_eb[i] <= 17'($signed(r_p2[47-16*i -: 16]))
                                 - 17'($signed(r_cp[0][47-16*i -: 16]));
                    end
                    r_k     <= '0;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_c[r_k] <= w_cr[34] ? 35'(-w_cr) : 35'(w_cr);
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_sum   <= '0;
                        r_qmode <= 1'b0;
                        r_state <= S_SQ;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_SQ: begin
                    r_sum <= r_sum + 72'(w_sq);
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_area <= w_root;
                        r_len  <= w_root[31:0];
                        r_k    <= '0;
                        if (r_qmode) begin
                            r_state <= S_DIVLD;
                        end else if ({4'b0, r_min_area} > w_root) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_CRD;
                        end
                    end
                end
                S_CRD: begin
                    if (w_cin) begin
                        r_state <= S_CMUL;
                    end else if (r_k == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_CMUL: begin
                    r_pr[0] <= 53'($signed(w_cn[47:32]) * w_area_s);
                    r_pr[1] <= 53'($signed(w_cn[31:16]) * w_area_s);
                    r_pr[2] <= 53'($signed(w_cn[15:0]) * w_area_s);
                    r_state <= S_CWR;
                end
                S_CWR: begin
                    if (r_k == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_CRD;
                    end
                end
                S_QDATA: begin
                    r_m[0]   <= mag(w_rd_data.x);
                    r_m[1]   <= mag(w_rd_data.y);
                    r_m[2]   <= mag(w_rd_data.z);
                    r_neg[0] <= w_rd_data.x[ACC_W-1];
                    r_neg[1] <= w_rd_data.y[ACC_W-1];
                    r_neg[2] <= w_rd_data.z[ACC_W-1];
                    if ((w_rd_data.x | w_rd_data.y | w_rd_data.z) == '0) begin
                        r_qo[0] <= '0;
                        r_qo[1] <= '0;
                        r_qo[2] <= '0;
                        r_qz    <= 1'b1;
                        r_state <= S_QOUT;
                    end else begin
                        r_qz    <= 1'b0;
                        r_state <= S_QSHIFT;
                    end
                end
                S_QSHIFT: begin
                    if (((r_m[0] | r_m[1] | r_m[2]) >> 31) != '0) begin
                        r_m[0] <= r_m[0] >> 1;
                        r_m[1] <= r_m[1] >> 1;
                        r_m[2] <= r_m[2] >> 1;
                    end else begin
                        r_k     <= '0;
                        r_sum   <= '0;
                        r_qmode <= 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_DIVLD: begin
                    r_num   <= 47'({r_m[r_k][30:0], 14'b0}) + 47'(r_len >> 1);
                    r_dsr   <= 47'({r_len, 14'b0});
                    r_q     <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_num <= r_num - r_dsr;
                    end
                    r_q    <= w_qfin;
                    r_dsr  <= r_dsr >> 1;
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd14) begin
                        r_qo[r_k] <= r_neg[r_k] ? -OUT_W'(w_qfin) : OUT_W'(w_qfin);
                        if (r_k == 2'd2) begin
                            r_state <= S_QOUT;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DIVLD;
                        end
                    end
                end
                S_QOUT: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ox    <= r_qo[0];
                        r_oy    <= r_qo[1];
                        r_oz    <= r_qo[2];
                        r_osz   <= r_qz;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_ov;
    assign o_rsp.out_x    = r_ox;
    assign o_rsp.out_y    = r_oy;
    assign o_rsp.out_z    = r_oz;
    assign o_rsp.sum_zero = r_osz;

    a_sqrt_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> (r_state == S_SQRT))
        else $error("root result outside its wait state");

    a_corner_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("corner count out of range");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.sum_zero) |->
        (o_rsp.out_x == '0 && o_rsp.out_y == '0 && o_rsp.out_z == '0))
        else $error("zero-sum response carries a non-zero vector");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CWR) |-> $past(r_state == S_CMUL) && $past(r_state == S_CRD, 2))
        else $error("accumulator write without its read");

endmodule
`default_nettype wire
